// File: rtl/uki_pkg.sv
// uki_pkg: shared constants for the unique key indexer
// no dependencies; imported by every module of the block
`default_nettype none

package uki_pkg;

    // default table size and key width
    localparam int unsigned UKI_TABLE_DEPTH = 1024;
    localparam int unsigned UKI_KEY_WIDTH   = 64;

    // widths of the counters kept per entry
    localparam int unsigned UKI_CNT_W = 32;
    localparam int unsigned UKI_POS_W = 32;

    // saturation value of counts and positions
    localparam logic [UKI_CNT_W-1:0] UKI_SAT = '1;

    // bit positions of the flags in the result tuser
    localparam int unsigned UKI_FLAG_NEW = 0;
    localparam int unsigned UKI_FLAG_ERR = 1;

endpackage

`default_nettype wire

// File: rtl/uki_ram.sv
// uki_ram: single write port, single read port memory, read data registered
// depends on uki_pkg
`default_nettype none

module uki_ram #(
    parameter int unsigned ADDR_W = 10,
    parameter int unsigned DATA_W = 128
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [DATA_W-1:0] i_wdata,
    input  wire logic              i_re,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [DATA_W-1:0] o_rdata
);
    import uki_pkg::*;

    logic [DATA_W-1:0] r_mem [2**ADDR_W];
    logic [DATA_W-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port, holds while not read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: rtl/unique_key_indexer.sv
// Path of an item: a lookup reads a hash slot (S_HRD) and checks it (S_HCHK) per probe;
// a hit then reads and updates its entry (S_ERD, S_EUPD); a new or refused key goes on
// to S_OUT; a read back passes S_ERD and S_EUPD; a bad read index goes to S_OUT. One
// item at a time; a stalled result holds the block in its output state.
// Reset (synchronous, active low) clears the counters and then sweeps the hash
// memory, all 2 * 2**clog2(TABLE_DEPTH) slots, with s_tready low.
// unique_key_indexer top level; depends on uki_pkg and uki_ram
`default_nettype none

module unique_key_indexer #(
    parameter int unsigned TABLE_DEPTH = uki_pkg::UKI_TABLE_DEPTH,
    parameter int unsigned KEY_WIDTH   = uki_pkg::UKI_KEY_WIDTH,
    localparam int unsigned ID_W   = $clog2(TABLE_DEPTH + 1),
    localparam int unsigned IN_DW  = ((KEY_WIDTH + ID_W + 7) / 8) * 8,
    localparam int unsigned OUT_DW = ((ID_W + 64 + KEY_WIDTH + 7) / 8) * 8
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // input items
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [IN_DW-1:0]  s_tdata,  // key, entry_index, zero pad
    input  wire logic              s_tuser,  // mode
    // result items
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic      [OUT_DW-1:0] m_tdata,  // key_id, occurrence_count,
                                             // first_position, stored_key, zero pad
    output logic      [1:0]        m_tuser   // is_new, error_flag
);
    import uki_pkg::*;

    localparam int unsigned AW  = $clog2(TABLE_DEPTH);
    localparam int unsigned HW  = AW + 1;
    localparam int unsigned HDW = ID_W + KEY_WIDTH;
    localparam int unsigned EDW = KEY_WIDTH + UKI_CNT_W + UKI_POS_W;

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_HRD   = 7'b0000100,
        S_HCHK  = 7'b0001000,
        S_ERD   = 7'b0010000,
        S_EUPD  = 7'b0100000,
        S_OUT   = 7'b1000000
    } t_state;

    typedef struct packed {
        logic [ID_W-1:0]      id;
        logic                 is_new;
        logic [UKI_CNT_W-1:0] cnt;
        logic [UKI_POS_W-1:0] pos;
        logic [KEY_WIDTH-1:0] skey;
        logic                 err;
    } t_res;

    t_state r_state, n_state;
    logic [HW-1:0]        r_clr, n_clr;
    logic [ID_W-1:0]      r_dc, n_dc;
    logic [UKI_POS_W-1:0] r_spos, n_spos;
    logic [KEY_WIDTH-1:0] r_key, n_key;
    logic [HW-1:0]        r_haddr, n_haddr;
    logic [AW-1:0]        r_eidx, n_eidx;
    logic                 r_rd, n_rd;
    t_res                 r_res, n_res;
    logic                 r_ovalid, n_ovalid;
    t_res                 r_out, n_out;

    // memory ports
    logic           h_we, h_re, e_we, e_re;
    logic [HW-1:0]  h_waddr;
    logic [HDW-1:0] h_wdata, h_rdata;
    logic [AW-1:0]  e_waddr;
    logic [EDW-1:0] e_wdata, e_rdata;

    // input fields
    logic [KEY_WIDTH-1:0] in_key;
    logic [ID_W-1:0]      in_idx;
    logic [HW-1:0]        in_hash;

    // probe slot and entry fields
    logic [ID_W-1:0]      slot_id;
    logic [KEY_WIDTH-1:0] slot_key;
    logic [KEY_WIDTH-1:0] ent_key;
    logic [UKI_CNT_W-1:0] ent_cnt, ent_cnt_inc;
    logic [UKI_POS_W-1:0] ent_pos;
    logic                 out_free, tbl_full;
    logic [ID_W-1:0]      new_id;

    assign in_key   = s_tdata[KEY_WIDTH-1:0];
    assign in_idx   = s_tdata[KEY_WIDTH +: ID_W];
    assign slot_id  = h_rdata[KEY_WIDTH +: ID_W];
    assign slot_key = h_rdata[KEY_WIDTH-1:0];
    assign ent_key  = e_rdata[KEY_WIDTH-1:0];
    assign ent_cnt  = e_rdata[KEY_WIDTH +: UKI_CNT_W];
    assign ent_pos  = e_rdata[KEY_WIDTH + UKI_CNT_W +: UKI_POS_W];
    assign ent_cnt_inc = (ent_cnt == UKI_SAT) ? ent_cnt : ent_cnt + 1'b1;
    assign out_free = !r_ovalid || m_tready;
    assign tbl_full = (r_dc == ID_W'(TABLE_DEPTH));
    assign new_id   = r_dc + 1'b1;

    // xor fold of the key onto the hash address
    always_comb begin
        in_hash = '0;
        for (int i = 0; i < int'(KEY_WIDTH); i++) begin
            in_hash[i % HW] = in_hash[i % HW] ^ in_key[i];
        end
    end

    // control and datapath
    always_comb begin
        n_state  = r_state;
        n_clr    = r_clr;
        n_dc     = r_dc;
        n_spos   = r_spos;
        n_key    = r_key;
        n_haddr  = r_haddr;
        n_eidx   = r_eidx;
        n_rd     = r_rd;
        n_res    = r_res;
        n_ovalid = r_ovalid && !m_tready;
        n_out    = r_out;
        h_we     = 1'b0;
        h_waddr  = r_haddr;
        h_wdata  = {new_id, r_key};
        h_re     = 1'b0;
        e_we     = 1'b0;
        e_waddr  = r_eidx;
        e_wdata  = {r_spos, UKI_CNT_W'(1), r_key};
        e_re     = 1'b0;
        s_tready = (r_state == S_IDLE);

        unique case (r_state)
            S_CLEAR: begin
                h_we    = 1'b1;
                h_waddr = r_clr;
                h_wdata = '0;
                n_clr   = r_clr + 1'b1;
                if (r_clr == '1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    if (!s_tuser) begin
                        n_key   = in_key;
                        n_spos  = (r_spos == UKI_SAT) ? r_spos : r_spos + 1'b1;
                        n_haddr = in_hash;
                        n_state = S_HRD;
                    end else if (in_idx != '0 && in_idx <= r_dc) begin
                        n_eidx   = AW'(in_idx - 1'b1);
                        n_res.id = in_idx;
                        n_rd     = 1'b1;
                        n_state  = S_ERD;
                    end else begin
                        n_res   = '{id: '0, is_new: 1'b0, cnt: '0, pos: '0,
                                    skey: '0, err: 1'b1};
                        n_state = S_OUT;
                    end
                end
            end
            S_HRD: begin
                h_re    = 1'b1;
                n_state = S_HCHK;
            end
            S_HCHK: begin
                priority if (slot_id != '0 && slot_key == r_key) begin
                    n_eidx   = AW'(slot_id - 1'b1);
                    n_res.id = slot_id;
                    n_rd     = 1'b0;
                    n_state  = S_ERD;
                end else if (slot_id == '0) begin
                    if (tbl_full) begin
                        n_res = '{id: '0, is_new: 1'b0, cnt: '0, pos: '0,
                                  skey: r_key, err: 1'b1};
                    end else begin
                        // claim the empty slot and the next entry
                        h_we    = 1'b1;
                        e_we    = 1'b1;
                        e_waddr = AW'(r_dc);
                        n_dc    = new_id;
                        n_res   = '{id: new_id, is_new: 1'b1, cnt: UKI_CNT_W'(1),
                                    pos: r_spos, skey: r_key, err: 1'b0};
                    end
                    n_state = S_OUT;
                end else begin
                    n_haddr = r_haddr + 1'b1;
                    n_state = S_HRD;
                end
            end
            S_ERD: begin
                e_re    = 1'b1;
                n_state = S_EUPD;
            end
            S_EUPD: begin
                if (r_rd) begin
                    n_res = '{id: r_res.id, is_new: 1'b0, cnt: ent_cnt, pos: ent_pos,
                              skey: ent_key, err: 1'b0};
                end else begin
                    e_we    = 1'b1;
                    e_wdata = {ent_pos, ent_cnt_inc, ent_key};
                    n_res   = '{id: r_res.id, is_new: 1'b0, cnt: ent_cnt_inc,
                                pos: ent_pos, skey: ent_key, err: 1'b0};
                end
                n_state = S_OUT;
            end
            S_OUT: begin
                if (out_free) begin
                    n_out    = r_res;
                    n_ovalid = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_dc     <= '0;
            r_spos   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_dc     <= n_dc;
            r_spos   <= n_spos;
            r_ovalid <= n_ovalid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_key   <= n_key;
        r_haddr <= n_haddr;
        r_eidx  <= n_eidx;
        r_rd    <= n_rd;
        r_res   <= n_res;
        r_out   <= n_out;
    end

    // hash slots: entry id (0 = empty) and key
    uki_ram #(
        .ADDR_W (HW),
        .DATA_W (HDW)
    ) u_hash_ram (
        .i_clk   (i_clk),
        .i_we    (h_we),
        .i_waddr (h_waddr),
        .i_wdata (h_wdata),
        .i_re    (h_re),
        .i_raddr (r_haddr),
        .o_rdata (h_rdata)
    );

    // entries by id: first position, count, key
    uki_ram #(
        .ADDR_W (AW),
        .DATA_W (EDW)
    ) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (e_we),
        .i_waddr (e_waddr),
        .i_wdata (e_wdata),
        .i_re    (e_re),
        .i_raddr (r_eidx),
        .o_rdata (e_rdata)
    );

    // result port
    assign m_tvalid = r_ovalid;
    assign m_tdata  = OUT_DW'({r_out.skey, r_out.pos, r_out.cnt, r_out.id});
    always_comb begin
        m_tuser               = '0;
        m_tuser[UKI_FLAG_NEW] = r_out.is_new;
        m_tuser[UKI_FLAG_ERR] = r_out.err;
    end

endmodule

`default_nettype wire

// File: rtl/uki_checker.sv
// uki_checker: port level checks of unique_key_indexer, bound to the top level
// depends on uki_pkg and unique_key_indexer
`default_nettype none

module uki_checker #(
    parameter int unsigned ID_W   = 11,
    parameter int unsigned OUT_DW = 144
) (
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              m_tvalid,
    input wire logic              m_tready,
    input wire logic [OUT_DW-1:0] m_tdata,
    input wire logic [1:0]        m_tuser
);
    import uki_pkg::*;

    logic [ID_W-1:0]      key_id;
    logic [UKI_CNT_W-1:0] occ_cnt;

    assign key_id  = m_tdata[ID_W-1:0];
    assign occ_cnt = m_tdata[ID_W +: UKI_CNT_W];

    // a stalled item holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result item changed while stalled");

    // an error carries no identifier
    a_err_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && m_tuser[UKI_FLAG_ERR] |-> key_id == '0)
        else $error("error item with nonzero key_id");

    // a good item always names an entry
    a_ok_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tuser[UKI_FLAG_ERR] |-> key_id != '0)
        else $error("good item with zero key_id");

    // a new key starts at count one and is no error
    a_new: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && m_tuser[UKI_FLAG_NEW] |->
            !m_tuser[UKI_FLAG_ERR] && occ_cnt == UKI_CNT_W'(1))
        else $error("new key item inconsistent");

endmodule

bind unique_key_indexer uki_checker #(
    .ID_W   (ID_W),
    .OUT_DW (OUT_DW)
) u_uki_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

// File: dv/tb_unique_key_indexer.sv
// tb_unique_key_indexer: stream test of the unique key indexer with its own
// key table predictor; depends on uki_pkg and the unique_key_indexer rtl
`default_nettype none

module tb_unique_key_indexer;
    timeunit 1ns;
    timeprecision 1ps;
    import uki_pkg::*;

    localparam int unsigned DEPTH    = UKI_TABLE_DEPTH;
    localparam int unsigned ID_W     = $clog2(DEPTH + 1);
    localparam int unsigned IN_DW    = ((UKI_KEY_WIDTH + ID_W + 7) / 8) * 8;
    localparam int unsigned OUT_DW   = ((ID_W + 64 + UKI_KEY_WIDTH + 7) / 8) * 8;
    localparam int unsigned N_RAND   = 1075;
    localparam int unsigned STALL_LIMIT = 20000;

    typedef enum logic {MODE_LOOKUP = 1'b0, MODE_READ = 1'b1} t_mode;

    typedef struct packed {
        t_mode                    mode;
        logic [UKI_KEY_WIDTH-1:0] key;
        logic [ID_W-1:0]          index;
    } t_req;

    typedef struct packed {
        logic [ID_W-1:0]          id;
        logic                     fresh;
        logic [UKI_CNT_W-1:0]     cnt;
        logic [UKI_POS_W-1:0]     first;
        logic [UKI_KEY_WIDTH-1:0] skey;
        logic                     err;
    } t_entry_info;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [IN_DW-1:0]   s_tdata = '0;  // key, entry_index, zero pad
    logic               s_tuser = 1'b0;  // mode
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [OUT_DW-1:0]  m_tdata;  // key_id, occurrence_count, first_position, stored_key, pad
    logic [1:0]         m_tuser;  // is_new, error_flag

    unique_key_indexer i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // key table predictor state
    logic [UKI_KEY_WIDTH-1:0] tbl_key [DEPTH];
    logic [UKI_CNT_W-1:0]     tbl_cnt [DEPTH];
    logic [UKI_POS_W-1:0]     tbl_first [DEPTH];
    int unsigned              n_distinct = 0;
    logic [UKI_POS_W-1:0]     stream_pos = '0;

    t_req        items_pending[$];
    t_entry_info expected_info[$];
    logic [UKI_KEY_WIDTH-1:0] key_pool[$];
    int unsigned n_sent = 0;
    int unsigned total_items = 0;
    int unsigned idle_cycles = 0;
    bit          failed = 1'b0;

    function automatic t_entry_info lookup_key(t_req r);
        t_entry_info res;
        res = '0;
        if (r.mode == MODE_READ) begin
            if (r.index == 0 || r.index > n_distinct) begin
                res.err = 1'b1;
            end else begin
                res.id    = r.index;
                res.cnt   = tbl_cnt[r.index-1];
                res.first = tbl_first[r.index-1];
                res.skey  = tbl_key[r.index-1];
            end
            return res;
        end
        if (stream_pos != UKI_SAT) stream_pos++;
        res.skey = r.key;
        for (int i = 0; i < n_distinct; i++) begin
            if (tbl_key[i] == r.key) begin
                if (tbl_cnt[i] != UKI_SAT) tbl_cnt[i]++;
                res.id    = ID_W'(i + 1);
                res.cnt   = tbl_cnt[i];
                res.first = tbl_first[i];
                return res;
            end
        end
        // table full: a new key is refused
        if (n_distinct >= DEPTH) begin
            res.err = 1'b1;
            return res;
        end
        tbl_key[n_distinct]   = r.key;
        tbl_cnt[n_distinct]   = 1;
        tbl_first[n_distinct] = stream_pos;
        n_distinct++;
        res.id    = ID_W'(n_distinct);
        res.fresh = 1'b1;
        res.cnt   = 1;
        res.first = stream_pos;
        return res;
    endfunction

    function automatic void add_item(t_mode m, logic [UKI_KEY_WIDTH-1:0] k,
                                     logic [ID_W-1:0] idx);
        t_req r;
        r.mode  = m;
        r.key   = k;
        r.index = idx;
        items_pending.insert(items_pending.size(), r);
        if (m == MODE_LOOKUP) key_pool.insert(key_pool.size(), k);
    endfunction

    // idle percentages per phase: sender/receiver 32/66, then 66/32, then none
    function automatic int unsigned send_idle();
        if (n_sent < total_items / 3) return 32;
        if (n_sent < 2 * total_items / 3) return 66;
        return 0;
    endfunction

    function automatic int unsigned recv_idle();
        if (n_sent < total_items / 3) return 66;
        if (n_sent < 2 * total_items / 3) return 32;
        return 0;
    endfunction

    // driver: next item from the pending queue
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (items_pending.size() != 0 && $urandom_range(99) >= send_idle()) begin
                t_req r;
                r = items_pending.pop_front();
                s_tdata  <= {{(IN_DW - UKI_KEY_WIDTH - ID_W){1'b0}}, r.index, r.key};
                s_tuser  <= r.mode;
                s_tvalid <= 1'b1;
                expected_info.insert(expected_info.size(), lookup_key(r));
                n_sent++;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // monitor: random m_tready, stall watchdog, and compare each result item with the oldest expectation
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle());
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
            if (m_tvalid && m_tready) begin
                t_entry_info got, exp_i;
                got.id    = m_tdata[ID_W-1:0];
                got.cnt   = m_tdata[ID_W +: UKI_CNT_W];
                got.first = m_tdata[ID_W + UKI_CNT_W +: UKI_POS_W];
                got.skey  = m_tdata[ID_W + UKI_CNT_W + UKI_POS_W +: UKI_KEY_WIDTH];
                got.fresh = m_tuser[UKI_FLAG_NEW];
                got.err   = m_tuser[UKI_FLAG_ERR];
                if (expected_info.size() == 0) begin
                    $display("%0t unexpected result id=%0d", $realtime, got.id);
                    failed = 1'b1;
                end else begin
                    exp_i = expected_info.pop_front();
                    if (got.id != exp_i.id) begin
                        $display("%0t key_id exp %0d got %0d", $realtime, exp_i.id, got.id);
                        failed = 1'b1;
                    end
                    if (got.fresh != exp_i.fresh) begin
                        $display("%0t is_new exp %0d got %0d", $realtime, exp_i.fresh,
                                 got.fresh);
                        failed = 1'b1;
                    end
                    if (got.cnt != exp_i.cnt) begin
                        $display("%0t count exp %0d got %0d", $realtime, exp_i.cnt, got.cnt);
                        failed = 1'b1;
                    end
                    if (got.first != exp_i.first) begin
                        $display("%0t first_pos exp %0d got %0d", $realtime, exp_i.first,
                                 got.first);
                        failed = 1'b1;
                    end
                    if (got.skey != exp_i.skey) begin
                        $display("%0t stored_key exp %h got %h", $realtime, exp_i.skey,
                                 got.skey);
                        failed = 1'b1;
                    end
                    if (got.err != exp_i.err) begin
                        $display("%0t error exp %0d got %0d", $realtime, exp_i.err, got.err);
                        failed = 1'b1;
                    end
                end
            end
        end
    end

    initial begin
        int unsigned pick;
        // directed: empty-table reads, extreme keys, hits, index extremes
        add_item(MODE_READ, '0, '0);
        add_item(MODE_READ, '1, 1);
        add_item(MODE_LOOKUP, '0, '0);
        add_item(MODE_LOOKUP, '1, '1);
        add_item(MODE_LOOKUP, '0, '0);
        add_item(MODE_LOOKUP, 64'hAAAA_AAAA_AAAA_AAAA, '0);
        add_item(MODE_LOOKUP, 64'h5555_5555_5555_5555, '1);
        add_item(MODE_LOOKUP, '1, '0);
        add_item(MODE_READ, '0, 1);
        add_item(MODE_READ, '1, 2);
        add_item(MODE_READ, '0, 4);
        add_item(MODE_READ, '0, 5);
        add_item(MODE_READ, '0, 0);
        add_item(MODE_READ, '0, '1);
        add_item(MODE_READ, '0, ID_W'(DEPTH));
        add_item(MODE_LOOKUP, 64'h8000_0000_0000_0001, '0);
        add_item(MODE_LOOKUP, 64'h8000_0000_0000_0001, '0);
        // random: new keys fill the table, every twentieth item a hit or a read
        for (int n = 0; n < N_RAND; n++) begin
            if (n % 20 != 19) begin
                add_item(MODE_LOOKUP, {$urandom, $urandom}, ID_W'($urandom));
            end else begin
                pick = $urandom_range(2);
                if (pick == 0) begin
                    add_item(MODE_LOOKUP, key_pool[$urandom_range(key_pool.size() - 1)],
                             ID_W'($urandom));
                end else if (pick == 1) begin
                    add_item(MODE_READ, {$urandom, $urandom},
                             ID_W'($urandom_range(n / 2 + 1, 1)));
                end else begin
                    add_item(MODE_READ, {$urandom, $urandom}, ID_W'($urandom));
                end
            end
        end
        // full table: hits, refused keys and reads at the top indices
        for (int n = 0; n < 20; n++) begin
            add_item(MODE_LOOKUP, key_pool[$urandom_range(key_pool.size() - 1)], '0);
            add_item(MODE_LOOKUP, {$urandom, $urandom}, '0);
            add_item(MODE_READ, '0, ID_W'(DEPTH - n));
        end
        total_items = items_pending.size();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (items_pending.size() == 0 && !s_tvalid && expected_info.size() == 0);
        repeat (50) @(posedge i_clk);
        if (!failed && expected_info.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

`default_nettype wire

// File: files.f
rtl/uki_pkg.sv
rtl/uki_ram.sv
rtl/unique_key_indexer.sv
rtl/uki_checker.sv
dv/tb_unique_key_indexer.sv
